[rtl/hvsub_pkg.sv]
`timescale 1ns / 1ps

package hvsub_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int PIX_W         = 8;

    // which channel holds the maximum; red wins ties over green, green over blue
    typedef enum logic [1:0] {
        MAX_RED,
        MAX_GREEN,
        MAX_BLUE
    } t_max_sel;

    // 60-degree hue sectors
    typedef enum logic [2:0] {
        SEC_0,
        SEC_1,
        SEC_2,
        SEC_3,
        SEC_4,
        SEC_5
    } t_sector;

    // per-pixel side data carried down the divider pipe
    typedef struct packed {
        logic             achrom;
        t_sector          sector;
        logic [PIX_W-1:0] gray;
    } t_pix_ctl;

endpackage

[rtl/hsv_value_substitution_core.sv]
`timescale 1ns / 1ps

// channel     dir  width  contents (lowest bits first)
// s_axis      in   32     red, green, blue, gray
// m_axis      out  24     red, green, blue
//
// One pixel per clock while no result is held; the pipe has two front
// stages (max/min, hue sector), FRAC_BITS restoring-divider stages that
// produce saturation and hue fraction one bit each, four product/select stages.
// i_rst_n is synchronous and clears the valid bits only.
// A held result freezes the whole pipe; s_axis tready follows that freeze.
module hsv_value_substitution_core #(
    parameter int FRAC_BITS = hvsub_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue, [31:24] gray
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata    // [7:0] red, [15:8] green, [23:16] blue
);

    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic w_en;

    logic                         w_valid [0:FRAC_BITS];
    hvsub_pkg::t_pix_ctl          w_ctl   [0:FRAC_BITS];
    logic [hvsub_pkg::PIX_W-1:0]  w_mx    [0:FRAC_BITS];
    logic [hvsub_pkg::PIX_W-1:0]  w_d     [0:FRAC_BITS];
    logic [FRAC_BITS:0]           w_s_q   [0:FRAC_BITS];
    logic [hvsub_pkg::PIX_W-1:0]  w_s_rem [0:FRAC_BITS];
    logic [FRAC_BITS-1:0]         w_f_q   [0:FRAC_BITS];
    logic [hvsub_pkg::PIX_W-1:0]  w_f_rem [0:FRAC_BITS];

    assign w_en            = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign w_f_q[0]        = '0;

    hvsub_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_axis_tvalid),
        .i_red   (i_s_axis_tdata[7:0]),
        .i_green (i_s_axis_tdata[15:8]),
        .i_blue  (i_s_axis_tdata[23:16]),
        .i_gray  (i_s_axis_tdata[31:24]),
        .o_valid (w_valid[0]),
        .o_ctl   (w_ctl[0]),
        .o_mx    (w_mx[0]),
        .o_d     (w_d[0]),
        .o_s_q   (w_s_q[0]),
        .o_s_rem (w_s_rem[0]),
        .o_f_rem (w_f_rem[0])
    );

    for (genvar k = 0; k < FRAC_BITS; k++) begin : g_div
        hvsub_div_stage #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[k]),
            .i_ctl   (w_ctl[k]),
            .i_mx    (w_mx[k]),
            .i_d     (w_d[k]),
            .i_s_q   (w_s_q[k]),
            .i_s_rem (w_s_rem[k]),
            .i_f_q   (w_f_q[k]),
            .i_f_rem (w_f_rem[k]),
            .o_valid (w_valid[k+1]),
            .o_ctl   (w_ctl[k+1]),
            .o_mx    (w_mx[k+1]),
            .o_d     (w_d[k+1]),
            .o_s_q   (w_s_q[k+1]),
            .o_s_rem (w_s_rem[k+1]),
            .o_f_q   (w_f_q[k+1]),
            .o_f_rem (w_f_rem[k+1])
        );
    end

    hvsub_mix #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_valid[FRAC_BITS]),
        .i_ctl   (w_ctl[FRAC_BITS]),
        .i_s     (w_s_q[FRAC_BITS]),
        .i_f     (w_f_q[FRAC_BITS]),
        .o_valid (o_m_axis_tvalid),
        .o_red   (o_m_axis_tdata[7:0]),
        .o_green (o_m_axis_tdata[15:8]),
        .o_blue  (o_m_axis_tdata[23:16])
    );

    // a held result must freeze the front of the pipe too
    a_stall_freezes_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> $stable(w_valid[0]))
        else $error("front stage moved during output stall");

    // hue remainder must be below d for a chromatic pixel
    a_rem_below_d: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid[0] && !w_ctl[0].achrom) |-> (w_f_rem[0] < w_d[0]))
        else $error("hue remainder not below d");

    // saturation quotient never exceeds one
    a_sat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid[FRAC_BITS] && !w_ctl[FRAC_BITS].achrom) |-> (w_s_q[FRAC_BITS] <= ONE))
        else $error("saturation quotient above one");

endmodule

[rtl/hvsub_front.sv]
`timescale 1ns / 1ps

module hvsub_front #(
    parameter int FRAC_BITS = hvsub_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [hvsub_pkg::PIX_W-1:0]    i_red,
    input  logic [hvsub_pkg::PIX_W-1:0]    i_green,
    input  logic [hvsub_pkg::PIX_W-1:0]    i_blue,
    input  logic [hvsub_pkg::PIX_W-1:0]    i_gray,
    output logic                           o_valid,
    output hvsub_pkg::t_pix_ctl            o_ctl,
    output logic [hvsub_pkg::PIX_W-1:0]    o_mx,
    output logic [hvsub_pkg::PIX_W-1:0]    o_d,
    output logic [FRAC_BITS:0]             o_s_q,
    output logic [hvsub_pkg::PIX_W-1:0]    o_s_rem,
    output logic [hvsub_pkg::PIX_W-1:0]    o_f_rem
);

    // stage 1: max / min
    logic                        r_valid1;
    logic [hvsub_pkg::PIX_W-1:0] r_r, r_g, r_b, r_v, r_mx, r_mn;
    hvsub_pkg::t_max_sel         r_sel;

    logic [hvsub_pkg::PIX_W-1:0] n_mx, n_mn;
    hvsub_pkg::t_max_sel         n_sel;

    always_comb begin
        if (i_red >= i_green && i_red >= i_blue) begin
            n_sel = hvsub_pkg::MAX_RED;
            n_mx  = i_red;
        end else if (i_green >= i_blue) begin
            n_sel = hvsub_pkg::MAX_GREEN;
            n_mx  = i_green;
        end else begin
            n_sel = hvsub_pkg::MAX_BLUE;
            n_mx  = i_blue;
        end
        n_mn = (i_red < i_green) ? i_red : i_green;
        n_mn = (n_mn < i_blue) ? n_mn : i_blue;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
        end else if (i_en) begin
            r_valid1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r   <= i_red;
            r_g   <= i_green;
            r_b   <= i_blue;
            r_v   <= i_gray;
            r_mx  <= n_mx;
            r_mn  <= n_mn;
            r_sel <= n_sel;
        end
    end

    // stage 2: hue position, sector, remainder, first saturation bit
    logic [hvsub_pkg::PIX_W-1:0] c_d;
    logic [10:0]                 c_d1, c_d2, c_d3, c_d4, c_d5, c_d6;
    logic signed [11:0]          c_hn_raw;
    logic [10:0]                 c_hue;
    logic [10:0]                 c_rem;
    hvsub_pkg::t_sector          c_sector;
    logic                        c_s_top;

    always_comb begin
        c_d  = r_mx - r_mn;
        c_d1 = 11'(c_d);
        c_d2 = c_d1 << 1;
        c_d4 = c_d1 << 2;
        c_d3 = c_d2 + c_d1;
        c_d5 = c_d4 + c_d1;
        c_d6 = c_d5 + c_d1;

        unique case (r_sel)
            hvsub_pkg::MAX_RED:
                c_hn_raw = $signed({4'b0, r_g}) - $signed({4'b0, r_b});
            hvsub_pkg::MAX_GREEN:
                c_hn_raw = $signed({1'b0, c_d2}) + $signed({4'b0, r_b})
                         - $signed({4'b0, r_r});
            hvsub_pkg::MAX_BLUE:
                c_hn_raw = $signed({1'b0, c_d4}) + $signed({4'b0, r_r})
                         - $signed({4'b0, r_g});
            default:
                c_hn_raw = '0;
        endcase

        if (c_hn_raw < 0) begin
            c_hue = 11'(c_hn_raw + $signed({1'b0, c_d6}));
        end else begin
            c_hue = 11'(c_hn_raw);
        end

        priority if (c_hue < c_d1) begin
            c_sector = hvsub_pkg::SEC_0;
            c_rem    = c_hue;
        end else if (c_hue < c_d2) begin
            c_sector = hvsub_pkg::SEC_1;
            c_rem    = c_hue - c_d1;
        end else if (c_hue < c_d3) begin
            c_sector = hvsub_pkg::SEC_2;
            c_rem    = c_hue - c_d2;
        end else if (c_hue < c_d4) begin
            c_sector = hvsub_pkg::SEC_3;
            c_rem    = c_hue - c_d3;
        end else if (c_hue < c_d5) begin
            c_sector = hvsub_pkg::SEC_4;
            c_rem    = c_hue - c_d4;
        end else begin
            c_sector = hvsub_pkg::SEC_5;
            c_rem    = c_hue - c_d5;
        end

        // d reaches mx only when min is zero: full saturation
        c_s_top = (c_d >= r_mx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_valid1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_ctl.achrom <= (r_mx == r_mn);
            o_ctl.sector <= c_sector;
            o_ctl.gray   <= r_v;
            o_mx         <= r_mx;
            o_d          <= c_d;
            o_s_q        <= {{FRAC_BITS{1'b0}}, c_s_top};
            o_s_rem      <= c_s_top ? (c_d - r_mx) : c_d;
            o_f_rem      <= c_rem[7:0];
        end
    end

endmodule

[rtl/hvsub_div_stage.sv]
`timescale 1ns / 1ps

// one restoring step of both quotients: s = d/mx and f = rem/d
module hvsub_div_stage #(
    parameter int FRAC_BITS = hvsub_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  hvsub_pkg::t_pix_ctl            i_ctl,
    input  logic [hvsub_pkg::PIX_W-1:0]    i_mx,
    input  logic [hvsub_pkg::PIX_W-1:0]    i_d,
    input  logic [FRAC_BITS:0]             i_s_q,
    input  logic [hvsub_pkg::PIX_W-1:0]    i_s_rem,
    input  logic [FRAC_BITS-1:0]           i_f_q,
    input  logic [hvsub_pkg::PIX_W-1:0]    i_f_rem,
    output logic                           o_valid,
    output hvsub_pkg::t_pix_ctl            o_ctl,
    output logic [hvsub_pkg::PIX_W-1:0]    o_mx,
    output logic [hvsub_pkg::PIX_W-1:0]    o_d,
    output logic [FRAC_BITS:0]             o_s_q,
    output logic [hvsub_pkg::PIX_W-1:0]    o_s_rem,
    output logic [FRAC_BITS-1:0]           o_f_q,
    output logic [hvsub_pkg::PIX_W-1:0]    o_f_rem
);

    logic [hvsub_pkg::PIX_W:0] c_s_sh, c_f_sh;
    logic                      c_s_bit, c_f_bit;

    always_comb begin
        c_s_sh  = {i_s_rem, 1'b0};
        c_f_sh  = {i_f_rem, 1'b0};
        c_s_bit = (c_s_sh >= {1'b0, i_mx});
        c_f_bit = (c_f_sh >= {1'b0, i_d});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_ctl   <= i_ctl;
            o_mx    <= i_mx;
            o_d     <= i_d;
            o_s_q   <= {i_s_q[FRAC_BITS-1:0], c_s_bit};
            o_s_rem <= c_s_bit ? 8'(c_s_sh - {1'b0, i_mx}) : c_s_sh[7:0];
            o_f_q   <= {i_f_q[FRAC_BITS-2:0], c_f_bit};
            o_f_rem <= c_f_bit ? 8'(c_f_sh - {1'b0, i_d}) : c_f_sh[7:0];
        end
    end

endmodule

[rtl/hvsub_mix.sv]
`timescale 1ns / 1ps

// p/q/t products and sector select, four register stages
module hvsub_mix #(
    parameter int FRAC_BITS = hvsub_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  hvsub_pkg::t_pix_ctl            i_ctl,
    input  logic [FRAC_BITS:0]             i_s,
    input  logic [FRAC_BITS-1:0]           i_f,
    output logic                           o_valid,
    output logic [hvsub_pkg::PIX_W-1:0]    o_red,
    output logic [hvsub_pkg::PIX_W-1:0]    o_green,
    output logic [hvsub_pkg::PIX_W-1:0]    o_blue
);

    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic                [2:0] r_valid;
    hvsub_pkg::t_pix_ctl       r_ctl1, r_ctl2, r_ctl3;
    logic [FRAC_BITS:0]        r_s, r_sf, r_fs;
    logic [FRAC_BITS:0]        r_ps, r_pq, r_pt;
    logic [hvsub_pkg::PIX_W-1:0] r_p, r_q, r_t;

    logic [2*FRAC_BITS:0]      c_sf_prod;
    logic [2*FRAC_BITS+1:0]    c_fs_prod;
    logic [FRAC_BITS:0]        c_one_f;
    logic [FRAC_BITS+8:0]      c_p_prod, c_q_prod, c_t_prod;

    always_comb begin
        c_one_f   = ONE - {1'b0, i_f};
        c_sf_prod = (2*FRAC_BITS+1)'(i_s) * (2*FRAC_BITS+1)'(i_f);
        c_fs_prod = (2*FRAC_BITS+2)'(c_one_f) * (2*FRAC_BITS+2)'(i_s);
        c_p_prod  = (FRAC_BITS+9)'(r_ctl2.gray) * (FRAC_BITS+9)'(r_ps);
        c_q_prod  = (FRAC_BITS+9)'(r_ctl2.gray) * (FRAC_BITS+9)'(r_pq);
        c_t_prod  = (FRAC_BITS+9)'(r_ctl2.gray) * (FRAC_BITS+9)'(r_pt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= {r_valid[1:0], i_valid};
            o_valid <= r_valid[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // s*f and (1-f)*s, both at most ONE after the shift
            r_ctl1 <= i_ctl;
            r_s    <= i_s;
            r_sf   <= c_sf_prod[2*FRAC_BITS:FRAC_BITS];
            r_fs   <= c_fs_prod[2*FRAC_BITS:FRAC_BITS];

            r_ctl2 <= r_ctl1;
            r_ps   <= ONE - r_s;
            r_pq   <= ONE - r_sf;
            r_pt   <= ONE - r_fs;

            r_ctl3 <= r_ctl2;
            r_p    <= c_p_prod[FRAC_BITS+7:FRAC_BITS];
            r_q    <= c_q_prod[FRAC_BITS+7:FRAC_BITS];
            r_t    <= c_t_prod[FRAC_BITS+7:FRAC_BITS];

            if (r_ctl3.achrom) begin
                o_red   <= r_ctl3.gray;
                o_green <= r_ctl3.gray;
                o_blue  <= r_ctl3.gray;
            end else begin
                unique case (r_ctl3.sector)
                    hvsub_pkg::SEC_0: begin
                        o_red <= r_ctl3.gray; o_green <= r_t; o_blue <= r_p;
                    end
                    hvsub_pkg::SEC_1: begin
                        o_red <= r_q; o_green <= r_ctl3.gray; o_blue <= r_p;
                    end
                    hvsub_pkg::SEC_2: begin
                        o_red <= r_p; o_green <= r_ctl3.gray; o_blue <= r_t;
                    end
                    hvsub_pkg::SEC_3: begin
                        o_red <= r_p; o_green <= r_q; o_blue <= r_ctl3.gray;
                    end
                    hvsub_pkg::SEC_4: begin
                        o_red <= r_t; o_green <= r_p; o_blue <= r_ctl3.gray;
                    end
                    default: begin
                        o_red <= r_ctl3.gray; o_green <= r_p; o_blue <= r_q;
                    end
                endcase
            end
        end
    end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int FB         = hvsub_pkg::FRAC_BITS_DEF;
    localparam int LATENCY    = FB + 6;
    localparam int CYCLE_MAX  = 250000;
    localparam int N_RANDOM   = 1290;
    localparam int HOLD_LEN   = 4 * LATENCY;
    localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};

    typedef struct packed {
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  v;
        logic        typed;
        logic [23:0] rgb;   // {blue, green, red}
    } t_pix_case;

    localparam int N_DIRECTED = 25;

    // typed rows: gray-level pixels, primaries at full brightness, zero brightness
    t_pix_case directed_cases [0:N_DIRECTED-1] = '{
        '{8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 24'h000000},
        '{8'd0,   8'd0,   8'd0,   8'd255, 1'b1, 24'hFFFFFF},
        '{8'd255, 8'd255, 8'd255, 8'd0,   1'b1, 24'h000000},
        '{8'd128, 8'd128, 8'd128, 8'd77,  1'b1, 24'h4D4D4D},
        '{8'd255, 8'd0,   8'd0,   8'd255, 1'b1, 24'h0000FF},
        '{8'd0,   8'd255, 8'd0,   8'd255, 1'b1, 24'h00FF00},
        '{8'd0,   8'd0,   8'd255, 8'd255, 1'b1, 24'hFF0000},
        '{8'd255, 8'd0,   8'd0,   8'd0,   1'b1, 24'h000000},
        '{8'd12,  8'd200, 8'd90,  8'd0,   1'b1, 24'h000000},
        '{8'd255, 8'd255, 8'd0,   8'd200, 1'b0, 24'h0},
        '{8'd0,   8'd200, 8'd200, 8'd180, 1'b0, 24'h0},
        '{8'd200, 8'd0,   8'd200, 8'd140, 1'b0, 24'h0},
        '{8'd255, 8'd0,   8'd10,  8'd255, 1'b0, 24'h0},
        '{8'd255, 8'd128, 8'd0,   8'd255, 1'b0, 24'h0},
        '{8'd128, 8'd255, 8'd0,   8'd255, 1'b0, 24'h0},
        '{8'd0,   8'd255, 8'd128, 8'd255, 1'b0, 24'h0},
        '{8'd0,   8'd128, 8'd255, 8'd255, 1'b0, 24'h0},
        '{8'd128, 8'd0,   8'd255, 8'd255, 1'b0, 24'h0},
        '{8'd255, 8'd0,   8'd128, 8'd255, 1'b0, 24'h0},
        '{8'd1,   8'd0,   8'd0,   8'd255, 1'b0, 24'h0},
        '{8'd255, 8'd254, 8'd254, 8'd128, 1'b0, 24'h0},
        '{8'd254, 8'd255, 8'd255, 8'd1,   1'b0, 24'h0},
        '{8'd170, 8'd85,  8'd43,  8'd99,  1'b0, 24'h0},
        '{8'd0,   8'd1,   8'd255, 8'd255, 1'b0, 24'h0},
        '{8'd85,  8'd170, 8'd255, 8'd128, 1'b0, 24'h0}
    };

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        pix_valid = 1'b0;
    logic        pix_ready;
    logic [31:0] pix_data  = '0;   // red, green, blue, gray
    logic        rgb_valid;
    logic        rgb_ready = 1'b0;
    logic [23:0] rgb_data;         // red, green, blue

    logic [23:0] expected_rgb_q [$];
    int          snd_idle_pct = 0;
    int          rcv_idle_pct = 0;
    int          hold_requests = 0;
    int          hold_served   = 0;
    int          hold_left     = 0;
    int          fails         = 0;
    int          cycle_cnt     = 0;
    int          n_gray        = 0;
    int          n_color       = 0;
    int          n_checked     = 0;

    hsv_value_substitution_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (pix_valid),
        .o_s_axis_tready (pix_ready),
        .i_s_axis_tdata  (pix_data),
        .o_m_axis_tvalid (rgb_valid),
        .i_m_axis_tready (rgb_ready),
        .o_m_axis_tdata  (rgb_data)
    );

    always #4 clk = ~clk;

    function automatic logic [7:0] scale_by(logic [7:0] v, logic [FB:0] factor);
        logic [FB+8:0] prod;
        prod = (FB+9)'(v) * (FB+9)'(factor);
        return prod[FB+7:FB];
    endfunction

    // brightness swap in HSV space; returns {blue, green, red}
    function automatic logic [23:0] recolor_pixel(logic [7:0] r, logic [7:0] g,
                                                  logic [7:0] b, logic [7:0] v);
        logic [7:0]           mx, mn, dlt, rem;
        logic [FB+7:0]        num;
        logic [FB:0]          sat, frac, sf, fs;
        logic [2*FB+1:0]      prod;
        logic [7:0]           p, q, t, ro, go, bo;
        hvsub_pkg::t_max_sel  msel;
        hvsub_pkg::t_sector   sec;
        int                   hn, sec_i;
        mx = (r > g) ? r : g;
        mx = (mx > b) ? mx : b;
        mn = (r < g) ? r : g;
        mn = (mn < b) ? mn : b;
        if (mx == mn) return {v, v, v};
        dlt = mx - mn;
        num = {dlt, {FB{1'b0}}};
        sat = (FB+1)'(num / mx);
        if (mx == r)      msel = hvsub_pkg::MAX_RED;
        else if (mx == g) msel = hvsub_pkg::MAX_GREEN;
        else              msel = hvsub_pkg::MAX_BLUE;
        case (msel)
            hvsub_pkg::MAX_RED:   hn = int'(g) - int'(b);
            hvsub_pkg::MAX_GREEN: hn = 2 * int'(dlt) + int'(b) - int'(r);
            default:              hn = 4 * int'(dlt) + int'(r) - int'(g);
        endcase
        if (hn < 0) hn += 6 * int'(dlt);
        sec_i = hn / int'(dlt);
        if (sec_i > 5) sec_i = 5;
        rem  = 8'(hn - sec_i * int'(dlt));
        num  = {rem, {FB{1'b0}}};
        frac = (FB+1)'(num / dlt);
        if (frac >= ONE) frac = ONE - (FB+1)'(1);
        prod = (2*FB+2)'(sat) * (2*FB+2)'(frac);
        sf   = (FB+1)'(prod >> FB);
        prod = (2*FB+2)'(ONE - frac) * (2*FB+2)'(sat);
        fs   = (FB+1)'(prod >> FB);
        p = scale_by(v, ONE - sat);
        q = scale_by(v, ONE - sf);
        t = scale_by(v, ONE - fs);
        sec = hvsub_pkg::t_sector'(sec_i);
        case (sec)
            hvsub_pkg::SEC_0: begin ro = v; go = t; bo = p; end
            hvsub_pkg::SEC_1: begin ro = q; go = v; bo = p; end
            hvsub_pkg::SEC_2: begin ro = p; go = v; bo = t; end
            hvsub_pkg::SEC_3: begin ro = p; go = q; bo = v; end
            hvsub_pkg::SEC_4: begin ro = t; go = p; bo = v; end
            default:          begin ro = v; go = p; bo = q; end
        endcase
        return {bo, go, ro};
    endfunction

    task automatic offer_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                               input logic [7:0] v, input logic typed,
                               input logic [23:0] typed_rgb);
        pix_valid <= 1'b1;
        pix_data  <= {v, b, g, r};
        @(posedge clk);
        while (!pix_ready) @(posedge clk);
        expected_rgb_q.push_back(typed ? typed_rgb : recolor_pixel(r, g, b, v));
        if (r == g && g == b) n_gray++;
        else                  n_color++;
        while ($urandom_range(99) < snd_idle_pct) begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic drain_results();
        pix_valid <= 1'b0;
        @(posedge clk);
        while (expected_rgb_q.size() > 0) @(posedge clk);
    endtask

    task automatic run_random(input int count);
        logic [7:0] r, g, b, v;
        int base, hi, lo;
        for (int i = 0; i < count; i++) begin
            r = 8'($urandom_range(255));
            g = 8'($urandom_range(255));
            b = 8'($urandom_range(255));
            v = 8'($urandom_range(255));
            case ($urandom_range(9))
                0: begin
                    g = r;
                    b = r;
                end
                1: begin
                    // two channels tie for the maximum
                    hi = $urandom_range(1, 255);
                    lo = $urandom_range(0, hi - 1);
                    case ($urandom_range(2))
                        0:       begin r = 8'(hi); g = 8'(hi); b = 8'(lo); end
                        1:       begin r = 8'(lo); g = 8'(hi); b = 8'(hi); end
                        default: begin r = 8'(hi); g = 8'(lo); b = 8'(hi); end
                    endcase
                end
                2: begin
                    // nearly gray: tiny spread between channels
                    base = $urandom_range(255);
                    r = (base + $urandom_range(3) > 255) ? 8'd255 : 8'(base + $urandom_range(3));
                    g = (base + $urandom_range(3) > 255) ? 8'd255 : 8'(base + $urandom_range(3));
                    b = (base + $urandom_range(3) > 255) ? 8'd255 : 8'(base + $urandom_range(3));
                end
                3: begin
                    r = $urandom_range(1) ? 8'd255 : 8'd0;
                    g = $urandom_range(1) ? 8'd254 : 8'd1;
                    b = $urandom_range(1) ? 8'd255 : 8'd0;
                    v = $urandom_range(1) ? 8'd255 : 8'd0;
                end
                default: ;
            endcase
            if (i == count / 2) hold_requests++;
            offer_pixel(r, g, b, v, 1'b0, 24'h0);
        end
    endtask

    // receiver: random back-pressure plus long hold-offs on request
    always @(posedge clk) begin
        if (!rst_n) begin
            rgb_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rgb_ready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_LEN;
            rgb_ready   <= 1'b0;
        end else begin
            rgb_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge clk) begin
        logic [23:0] exp_rgb;
        if (rst_n && rgb_valid && rgb_ready) begin
            if (expected_rgb_q.size() == 0) begin
                $error("unexpected result rgb=%h", rgb_data);
                fails++;
            end else begin
                exp_rgb = expected_rgb_q.pop_front();
                n_checked++;
                if (rgb_data[7:0] !== exp_rgb[7:0]) begin
                    $error("red_out: expected %0d, got %0d", exp_rgb[7:0], rgb_data[7:0]);
                    fails++;
                end
                if (rgb_data[15:8] !== exp_rgb[15:8]) begin
                    $error("green_out: expected %0d, got %0d", exp_rgb[15:8], rgb_data[15:8]);
                    fails++;
                end
                if (rgb_data[23:16] !== exp_rgb[23:16]) begin
                    $error("blue_out: expected %0d, got %0d", exp_rgb[23:16], rgb_data[23:16]);
                    fails++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_MAX) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        snd_idle_pct = 35;
        rcv_idle_pct = 77;
        for (int i = 0; i < N_DIRECTED; i++)
            offer_pixel(directed_cases[i].r, directed_cases[i].g, directed_cases[i].b,
                        directed_cases[i].v, directed_cases[i].typed, directed_cases[i].rgb);
        run_random(N_RANDOM / 3);
        drain_results();

        snd_idle_pct = 77;
        rcv_idle_pct = 35;
        run_random(N_RANDOM / 3);
        drain_results();

        // steady sender against a long receiver hold-off fills the pipe
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        hold_requests++;
        run_random(N_RANDOM - 2 * (N_RANDOM / 3));

        pix_valid <= 1'b0;
        while (expected_rgb_q.size() > 0) @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);

        $display("run: %0d pixels sent (%0d gray-level, %0d colored), %0d results checked",
                 n_gray + n_color, n_gray, n_color, n_checked);
        $display("run: %0d long receiver hold-offs, %0d mismatches", hold_served, fails);
        if (fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
